>>> rtl/sca_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the sector chain allocator: request, entry-status and
// result codes, the microcode control word, the sequencer flag group and the step addresses.
// Has no dependencies; every other file of the block uses it.
package sca_pkg;

  // Request codes carried by the input transfer.
  localparam logic [2:0] REQ_FORMAT = 3'd0;
  localparam logic [2:0] REQ_LOAD   = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_ALLOC  = 3'd3;
  localparam logic [2:0] REQ_FREE   = 3'd4;
  localparam logic [2:0] REQ_LOCATE = 3'd5;

  // Entry status codes stored in the allocation table.
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_HEAD    = 2'd1;
  localparam logic [1:0] ST_USED    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // Result status codes.
  localparam logic [1:0] RES_OK   = 2'd0;
  localparam logic [1:0] RES_FULL = 2'd1;
  localparam logic [1:0] RES_BAD  = 2'd2;

  // Microprogram step address.
  typedef logic [4:0] upc_t;

  localparam upc_t UP_IDLE    = 5'd0;
  localparam upc_t UP_DONE    = 5'd1;
  localparam upc_t UP_BAD     = 5'd2;
  localparam upc_t UP_FULL    = 5'd3;
  localparam upc_t UP_FORMAT  = 5'd4;
  localparam upc_t UP_LOAD    = 5'd5;
  localparam upc_t UP_READ0   = 5'd6;
  localparam upc_t UP_READ1   = 5'd7;
  localparam upc_t UP_ALLOC0  = 5'd8;
  localparam upc_t UP_ALLOC1  = 5'd9;
  localparam upc_t UP_ALLOC2  = 5'd10;
  localparam upc_t UP_ALLOC3  = 5'd11;
  localparam upc_t UP_FREE0   = 5'd12;
  localparam upc_t UP_FREE1   = 5'd13;
  localparam upc_t UP_FREE2   = 5'd14;
  localparam upc_t UP_LOC0    = 5'd15;
  localparam upc_t UP_LOC1    = 5'd16;
  localparam upc_t UP_LOC2    = 5'd17;
  localparam upc_t UP_LOC3    = 5'd18;
  localparam upc_t UP_LOC4    = 5'd19;
  localparam upc_t UP_LOC5    = 5'd20;
  localparam upc_t UP_LOC6    = 5'd21;
  localparam upc_t UP_LOC7    = 5'd22;
  localparam upc_t UP_LOC_OUT = 5'd23;

  // Table read address source.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_SEC,
    RD_NEXT,
    RD_PTR
  } rd_sel_t;

  // Table write source.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_LOAD,
    WR_HEAD,
    WR_LINK,
    WR_USED
  } wr_sel_t;

  // Valid-bit operations.
  typedef enum logic [1:0] {
    VAL_NONE,
    VAL_CLEAR_ALL,
    VAL_CLEAR_CUR
  } val_op_t;

  // Empty-scan operations.
  typedef enum logic [1:0] {
    SCAN_NONE,
    SCAN_INIT,
    SCAN_STEP
  } scan_op_t;

  // Result register updates.
  typedef enum logic [2:0] {
    RES_NONE,
    RES_ENTRY,
    RES_FOUND,
    RES_LOC,
    RES_SET_FULL,
    RES_SET_BAD
  } res_op_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_HEAD,
    COND_CHAIN_END,
    COND_HOP_END,
    COND_NO_EXTEND,
    COND_SCAN_END,
    COND_NO_HIT,
    COND_OUT_FREE
  } cond_t;

  // What the step does when its condition is false.
  typedef enum logic {
    SEQ_NEXT,
    SEQ_STAY
  } seq_t;

  // Whether the datapath actions of a step run always or only when it does not jump.
  typedef enum logic {
    ACT_ALWAYS,
    ACT_IF_STAY
  } act_mode_t;

  // One microcode control word.
  typedef struct packed {
    logic      accept;
    rd_sel_t   rd_sel;
    wr_sel_t   wr_sel;
    val_op_t   val_op;
    scan_op_t  scan_op;
    logic      cnt_inc;
    logic      cur_next;
    logic      rem_sub;
    logic      keep_stat;
    res_op_t   res_op;
    logic      out_load;
    cond_t     cond;
    seq_t      seq;
    act_mode_t act_mode;
    upc_t      target;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    accept:    1'b0,
    rd_sel:    RD_NONE,
    wr_sel:    WR_NONE,
    val_op:    VAL_NONE,
    scan_op:   SCAN_NONE,
    cnt_inc:   1'b0,
    cur_next:  1'b0,
    rem_sub:   1'b0,
    keep_stat: 1'b0,
    res_op:    RES_NONE,
    out_load:  1'b0,
    cond:      COND_NEVER,
    seq:       SEQ_NEXT,
    act_mode:  ACT_ALWAYS,
    target:    UP_IDLE
  };

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic not_head;
    logic chain_end;
    logic hop_end;
    logic no_extend;
    logic scan_end;
    logic no_hit;
    logic out_free;
  } flags_t;

endpackage

>>> rtl/sca_table.sv
`timescale 1ns / 1ps
// Allocation table: one write port, one registered read port, and a valid bit per entry
// so that reset and format take effect at once. Depends on sca_pkg for the status codes.
module sca_table #(
  parameter int SECTOR_COUNT = 64,
  parameter int SW           = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [SW-1:0] wr_addr,
  input  logic [SW-1:0] wr_next,
  input  logic [1:0]    wr_stat,
  input  logic          clr_all,
  input  logic          clr_en,
  input  logic [SW-1:0] clr_addr,
  input  logic          rd_en,
  input  logic [SW-1:0] rd_addr,
  output logic [SW-1:0] rd_next,
  output logic [1:0]    rd_stat,
  output logic [SW-1:0] rd_addr_q
);

  logic [SW+1:0]           mem [SECTOR_COUNT];
  logic [SW+1:0]           mem_q;
  logic                    rv_q;
  logic [SW-1:0]           addr_q;
  logic [SECTOR_COUNT-1:0] valid_r;
  logic [SECTOR_COUNT-1:0] valid_nxt;

  // Entry storage; written as {next, status}.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_next, wr_stat};
    end
  end

  // Registered read of data, valid bit and address.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q  <= mem[rd_addr];
      rv_q   <= valid_r[rd_addr];
      addr_q <= rd_addr;
    end
  end

  // Valid bits: a write marks an entry, a clear returns it to its reset value.
  always_comb begin
    valid_nxt = valid_r;
    if (clr_all) begin
      valid_nxt = '0;
    end else begin
      if (clr_en) begin
        valid_nxt[clr_addr] = 1'b0;
      end
      if (wr_en) begin
        valid_nxt[wr_addr] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // An entry never written reads as its reset value: sector 0 used, all others empty.
  always_comb begin
    if (rv_q) begin
      rd_next = mem_q[SW+1:2];
      rd_stat = mem_q[1:0];
    end else begin
      rd_next = '0;
      rd_stat = (addr_q == '0) ? sca_pkg::ST_USED : sca_pkg::ST_EMPTY;
    end
  end

  assign rd_addr_q = addr_q;

endmodule

>>> rtl/sca_sequencer.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, the read-only control program and the jump logic.
// Depends on sca_pkg for the control word, flag group and step addresses.
module sca_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  sca_pkg::upc_t   start_upc,
  input  sca_pkg::flags_t flags,
  output sca_pkg::ctrl_t  ctrl,
  output logic            act
);

  sca_pkg::upc_t upc_r;
  sca_pkg::upc_t upc_nxt;
  logic          jump;

  // Control program, one word per step.
  function automatic sca_pkg::ctrl_t rom_word(input sca_pkg::upc_t a);
    sca_pkg::ctrl_t w;
    w = sca_pkg::CTRL_NOP;
    unique case (a)
      sca_pkg::UP_IDLE: begin
        w.accept = 1'b1;
        w.seq    = sca_pkg::SEQ_STAY;
      end
      sca_pkg::UP_DONE: begin
        w.out_load = 1'b1;
        w.cond     = sca_pkg::COND_OUT_FREE;
        w.seq      = sca_pkg::SEQ_STAY;
        w.target   = sca_pkg::UP_IDLE;
      end
      sca_pkg::UP_BAD: begin
        w.res_op = sca_pkg::RES_SET_BAD;
        w.cond   = sca_pkg::COND_ALWAYS;
        w.target = sca_pkg::UP_DONE;
      end
      sca_pkg::UP_FULL: begin
        w.res_op = sca_pkg::RES_SET_FULL;
        w.cond   = sca_pkg::COND_ALWAYS;
        w.target = sca_pkg::UP_DONE;
      end
      sca_pkg::UP_FORMAT: begin
        w.val_op = sca_pkg::VAL_CLEAR_ALL;
        w.cond   = sca_pkg::COND_ALWAYS;
        w.target = sca_pkg::UP_DONE;
      end
      sca_pkg::UP_LOAD: begin
        w.wr_sel = sca_pkg::WR_LOAD;
        w.cond   = sca_pkg::COND_ALWAYS;
        w.target = sca_pkg::UP_DONE;
      end
      sca_pkg::UP_READ0: begin
        w.rd_sel = sca_pkg::RD_SEC;
      end
      sca_pkg::UP_READ1: begin
        w.res_op = sca_pkg::RES_ENTRY;
        w.cond   = sca_pkg::COND_ALWAYS;
        w.target = sca_pkg::UP_DONE;
      end
      sca_pkg::UP_ALLOC0: begin
        w.scan_op = sca_pkg::SCAN_INIT;
      end
      sca_pkg::UP_ALLOC1: begin
        w.rd_sel  = sca_pkg::RD_PTR;
        w.scan_op = sca_pkg::SCAN_STEP;
        w.cnt_inc = 1'b1;
        w.cond    = sca_pkg::COND_SCAN_END;
        w.seq     = sca_pkg::SEQ_STAY;
        w.target  = sca_pkg::UP_ALLOC2;
      end
      sca_pkg::UP_ALLOC2: begin
        w.cond   = sca_pkg::COND_NO_HIT;
        w.target = sca_pkg::UP_FULL;
      end
      sca_pkg::UP_ALLOC3: begin
        w.wr_sel = sca_pkg::WR_HEAD;
        w.res_op = sca_pkg::RES_FOUND;
        w.cond   = sca_pkg::COND_ALWAYS;
        w.target = sca_pkg::UP_DONE;
      end
      sca_pkg::UP_FREE0: begin
        w.rd_sel = sca_pkg::RD_SEC;
      end
      sca_pkg::UP_FREE1: begin
        w.cond   = sca_pkg::COND_NOT_HEAD;
        w.target = sca_pkg::UP_BAD;
      end
      sca_pkg::UP_FREE2: begin
        w.val_op   = sca_pkg::VAL_CLEAR_CUR;
        w.rd_sel   = sca_pkg::RD_NEXT;
        w.cur_next = 1'b1;
        w.cnt_inc  = 1'b1;
        w.cond     = sca_pkg::COND_CHAIN_END;
        w.seq      = sca_pkg::SEQ_STAY;
        w.target   = sca_pkg::UP_DONE;
      end
      sca_pkg::UP_LOC0: begin
        w.rd_sel = sca_pkg::RD_SEC;
      end
      sca_pkg::UP_LOC1: begin
        w.rd_sel   = sca_pkg::RD_NEXT;
        w.cur_next = 1'b1;
        w.rem_sub  = 1'b1;
        w.act_mode = sca_pkg::ACT_IF_STAY;
        w.cond     = sca_pkg::COND_HOP_END;
        w.seq      = sca_pkg::SEQ_STAY;
        w.target   = sca_pkg::UP_LOC2;
      end
      sca_pkg::UP_LOC2: begin
        w.keep_stat = 1'b1;
        w.cond      = sca_pkg::COND_NO_EXTEND;
        w.target    = sca_pkg::UP_LOC_OUT;
      end
      sca_pkg::UP_LOC3: begin
        w.scan_op = sca_pkg::SCAN_INIT;
      end
      sca_pkg::UP_LOC4: begin
        w.rd_sel  = sca_pkg::RD_PTR;
        w.scan_op = sca_pkg::SCAN_STEP;
        w.cnt_inc = 1'b1;
        w.cond    = sca_pkg::COND_SCAN_END;
        w.seq     = sca_pkg::SEQ_STAY;
        w.target  = sca_pkg::UP_LOC5;
      end
      sca_pkg::UP_LOC5: begin
        w.cond   = sca_pkg::COND_NO_HIT;
        w.target = sca_pkg::UP_FULL;
      end
      sca_pkg::UP_LOC6: begin
        w.wr_sel = sca_pkg::WR_LINK;
      end
      sca_pkg::UP_LOC7: begin
        w.wr_sel = sca_pkg::WR_USED;
        w.res_op = sca_pkg::RES_FOUND;
        w.cond   = sca_pkg::COND_ALWAYS;
        w.target = sca_pkg::UP_DONE;
      end
      sca_pkg::UP_LOC_OUT: begin
        w.res_op = sca_pkg::RES_LOC;
        w.cond   = sca_pkg::COND_ALWAYS;
        w.target = sca_pkg::UP_DONE;
      end
      default: begin
        w.cond   = sca_pkg::COND_ALWAYS;
        w.target = sca_pkg::UP_IDLE;
      end
    endcase
    return w;
  endfunction

  assign ctrl = rom_word(upc_r);

  // Condition select.
  always_comb begin
    unique case (ctrl.cond)
      sca_pkg::COND_NEVER:     jump = 1'b0;
      sca_pkg::COND_ALWAYS:    jump = 1'b1;
      sca_pkg::COND_NOT_HEAD:  jump = flags.not_head;
      sca_pkg::COND_CHAIN_END: jump = flags.chain_end;
      sca_pkg::COND_HOP_END:   jump = flags.hop_end;
      sca_pkg::COND_NO_EXTEND: jump = flags.no_extend;
      sca_pkg::COND_SCAN_END:  jump = flags.scan_end;
      sca_pkg::COND_NO_HIT:    jump = flags.no_hit;
      sca_pkg::COND_OUT_FREE:  jump = flags.out_free;
      default:                 jump = 1'b0;
    endcase
  end

  assign act = (ctrl.act_mode == sca_pkg::ACT_ALWAYS) || !jump;

  // Step counter: dispatch from idle, jump, advance or hold.
  always_comb begin
    upc_nxt = upc_r;
    if (ctrl.accept) begin
      if (start) begin
        upc_nxt = start_upc;
      end
    end else if (jump) begin
      upc_nxt = ctrl.target;
    end else if (ctrl.seq == sca_pkg::SEQ_NEXT) begin
      upc_nxt = upc_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= sca_pkg::UP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

>>> rtl/sector_chain_allocator.sv
`timescale 1ns / 1ps
// Sector chain allocator: a microcoded sequencer over an allocation table with one write and one read port.
// Uses sca_pkg, sca_table and sca_sequencer.
//
// Usage: one request is taken per input transfer (in_valid high, in_stall low) and gives
// exactly one result transfer on the out_ channel. One request is worked on at a time;
// in_stall is low only while the sequencer sits in its idle step.
// Work per request before the result is loaded into the output register:
//   format clears all valid bits, load writes one entry, read entry reads one entry.
//   allocate head: an empty scan of at most SECTOR_COUNT - 1 entries.
//   free chain: the chain is cleared sector by sector, at most SECTOR_COUNT sectors.
//   locate: byte_position / SECTOR_BYTES links are followed; a chain extension
//   on a sector boundary adds an empty scan and the link and entry writes.
// The next request is taken in the cycle after the result is loaded. The pace is set
// by the table's one registered read per cycle: the empty scan and the chain walk visit one
// entry per cycle. A request that fails its checks goes to the bad-result step, then finishes.
// Reset (rst_n low, synchronous) clears all valid bits, so the table reads as formatted
// at once: no clearing pass. While out_stall holds a result, the sequencer waits in its
// final step and the result registers hold their values.
module sector_chain_allocator #(
  parameter int SECTOR_COUNT = 64,
  parameter int SECTOR_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [5:0]  in_sector,
  input  logic [14:0] in_byte_position,
  input  logic        in_at_end,
  input  logic [5:0]  in_start_hint,
  input  logic [5:0]  in_load_next,
  input  logic [1:0]  in_load_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_result_sector,
  output logic [8:0]  out_sector_offset,
  output logic [5:0]  out_entry_next,
  output logic [1:0]  out_entry_status,
  output logic [1:0]  out_status
);

  localparam int              SW       = $clog2(SECTOR_COUNT);
  localparam logic [7:0]      N_L      = 8'(SECTOR_COUNT);
  localparam logic [SW-1:0]   LAST_SEC = SW'(SECTOR_COUNT - 1);
  localparam logic [SW-1:0]   LAST_M1  = SW'(SECTOR_COUNT - 2);
  localparam logic [SW-1:0]   FIRST    = SW'(1);
  localparam logic [14:0]     SB_L     = 15'(SECTOR_BYTES);

  sca_pkg::ctrl_t  ctrl;
  sca_pkg::flags_t flags;
  sca_pkg::upc_t   start_upc;
  logic            act;
  logic            accept;
  logic            out_free;
  logic            sec_ok;
  logic            sec_nz;
  logic            lnext_ok;
  logic            hint_ok;

  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] rd_next;
  logic [1:0]    rd_stat;
  logic [SW-1:0] rd_addr_q;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [SW-1:0] wr_next;
  logic [1:0]    wr_stat;
  logic          clr_all;
  logic          clr_en;

  // Request fields and walk and scan state.
  logic [SW-1:0] sec_r, sec_nxt;
  logic [SW-1:0] s0_r, s0_nxt;
  logic          at_end_r, at_end_nxt;
  logic [SW-1:0] lnext_r, lnext_nxt;
  logic [1:0]    lstat_r, lstat_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [14:0]   rem_r, rem_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] ptr_r, ptr_nxt;
  logic          pend_r, pend_nxt;
  logic          last_r, last_nxt;
  logic          hit_r, hit_nxt;
  logic [SW-1:0] found_r, found_nxt;
  logic [1:0]    keep_r, keep_nxt;

  // Working result and output register.
  logic [5:0] wsec_r, wsec_nxt;
  logic [8:0] woff_r, woff_nxt;
  logic [5:0] wnext_r, wnext_nxt;
  logic [1:0] wstat_r, wstat_nxt;
  logic [1:0] wres_r, wres_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [5:0] osec_r, osec_nxt;
  logic [8:0] ooff_r, ooff_nxt;
  logic [5:0] onext_r, onext_nxt;
  logic [1:0] ostat_r, ostat_nxt;
  logic [1:0] ores_r, ores_nxt;

  assign in_stall = !ctrl.accept;
  assign accept   = in_valid && ctrl.accept;
  assign out_free = !ovalid_r || !out_stall;

  // Request checks and the entry step of each request.
  assign sec_ok   = {2'b00, in_sector} < N_L;
  assign sec_nz   = in_sector != 6'd0;
  assign lnext_ok = {2'b00, in_load_next} < N_L;
  assign hint_ok  = (in_start_hint != 6'd0) && ({2'b00, in_start_hint} < N_L);

  always_comb begin
    unique case (in_req_type)
      sca_pkg::REQ_FORMAT: start_upc = sca_pkg::UP_FORMAT;
      sca_pkg::REQ_LOAD: begin
        start_upc = (sec_ok && lnext_ok && (in_load_status != sca_pkg::ST_INVALID)) ?
                    sca_pkg::UP_LOAD : sca_pkg::UP_BAD;
      end
      sca_pkg::REQ_READ:   start_upc = sec_ok ? sca_pkg::UP_READ0 : sca_pkg::UP_BAD;
      sca_pkg::REQ_ALLOC:  start_upc = sca_pkg::UP_ALLOC0;
      sca_pkg::REQ_FREE: begin
        start_upc = (sec_ok && sec_nz) ? sca_pkg::UP_FREE0 : sca_pkg::UP_BAD;
      end
      sca_pkg::REQ_LOCATE: begin
        start_upc = (sec_ok && sec_nz) ? sca_pkg::UP_LOC0 : sca_pkg::UP_BAD;
      end
      default:             start_upc = sca_pkg::UP_BAD;
    endcase
  end

  // Status for the sequencer's jumps.
  always_comb begin
    flags.not_head  = rd_stat != sca_pkg::ST_HEAD;
    flags.chain_end = (rd_next == cur_r) || (rd_next == '0) || (cnt_r == LAST_SEC);
    flags.hop_end   = rem_r < SB_L;
    flags.no_extend = !(at_end_r && (rem_r == 15'd0));
    flags.scan_end  = pend_r && ((rd_stat == sca_pkg::ST_EMPTY) || last_r);
    flags.no_hit    = !hit_r;
    flags.out_free  = out_free;
  end

  sca_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .start_upc (start_upc),
    .flags     (flags),
    .ctrl      (ctrl),
    .act       (act)
  );

  // Table read address.
  always_comb begin
    case (ctrl.rd_sel)
      sca_pkg::RD_SEC:  rd_addr = sec_r;
      sca_pkg::RD_NEXT: rd_addr = rd_next;
      sca_pkg::RD_PTR:  rd_addr = ptr_r;
      default:          rd_addr = sec_r;
    endcase
  end
  assign rd_en = act && (ctrl.rd_sel != sca_pkg::RD_NONE);

  // Table write port.
  always_comb begin
    wr_en   = act;
    wr_addr = found_r;
    wr_next = found_r;
    wr_stat = sca_pkg::ST_USED;
    case (ctrl.wr_sel)
      sca_pkg::WR_LOAD: begin
        wr_addr = sec_r;
        wr_next = lnext_r;
        wr_stat = lstat_r;
      end
      sca_pkg::WR_HEAD: begin
        wr_stat = sca_pkg::ST_HEAD;
      end
      sca_pkg::WR_LINK: begin
        wr_addr = cur_r;
        wr_stat = keep_r;
      end
      sca_pkg::WR_USED: begin
        wr_stat = sca_pkg::ST_USED;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign clr_all = act && (ctrl.val_op == sca_pkg::VAL_CLEAR_ALL);
  assign clr_en  = act && (ctrl.val_op == sca_pkg::VAL_CLEAR_CUR);

  sca_table #(
    .SECTOR_COUNT (SECTOR_COUNT),
    .SW           (SW)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_next   (wr_next),
    .wr_stat   (wr_stat),
    .clr_all   (clr_all),
    .clr_en    (clr_en),
    .clr_addr  (cur_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_next   (rd_next),
    .rd_stat   (rd_stat),
    .rd_addr_q (rd_addr_q)
  );

  // Datapath: capture the request on its transfer, then apply the step's actions.
  always_comb begin
    sec_nxt    = sec_r;
    s0_nxt     = s0_r;
    at_end_nxt = at_end_r;
    lnext_nxt  = lnext_r;
    lstat_nxt  = lstat_r;
    cur_nxt    = cur_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    pend_nxt   = pend_r;
    last_nxt   = last_r;
    hit_nxt    = hit_r;
    found_nxt  = found_r;
    keep_nxt   = keep_r;
    wsec_nxt   = wsec_r;
    woff_nxt   = woff_r;
    wnext_nxt  = wnext_r;
    wstat_nxt  = wstat_r;
    wres_nxt   = wres_r;
    if (accept) begin
      sec_nxt    = SW'(in_sector);
      s0_nxt     = hint_ok ? SW'(in_start_hint) : FIRST;
      at_end_nxt = in_at_end;
      lnext_nxt  = SW'(in_load_next);
      lstat_nxt  = in_load_status;
      cur_nxt    = SW'(in_sector);
      rem_nxt    = in_byte_position;
      cnt_nxt    = '0;
      wsec_nxt   = '0;
      woff_nxt   = '0;
      wnext_nxt  = '0;
      wstat_nxt  = '0;
      wres_nxt   = sca_pkg::RES_OK;
    end else if (act) begin
      if (ctrl.cur_next) begin
        cur_nxt = rd_next;
      end
      if (ctrl.rem_sub) begin
        rem_nxt = rem_r - SB_L;
      end
      if (ctrl.cnt_inc) begin
        cnt_nxt = cnt_r + FIRST;
      end
      if (ctrl.keep_stat) begin
        keep_nxt = rd_stat;
      end
      // Empty scan: s0 up to the last sector, then wrap to sector 1.
      case (ctrl.scan_op)
        sca_pkg::SCAN_INIT: begin
          ptr_nxt  = s0_r;
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
          last_nxt = 1'b0;
          hit_nxt  = 1'b0;
        end
        sca_pkg::SCAN_STEP: begin
          ptr_nxt  = (ptr_r == LAST_SEC) ? FIRST : ptr_r + FIRST;
          pend_nxt = 1'b1;
          last_nxt = cnt_r == LAST_M1;
          if (pend_r && (rd_stat == sca_pkg::ST_EMPTY)) begin
            hit_nxt   = 1'b1;
            found_nxt = rd_addr_q;
          end
        end
        default: begin
        end
      endcase
      case (ctrl.res_op)
        sca_pkg::RES_ENTRY: begin
          wnext_nxt = 6'(rd_next);
          wstat_nxt = rd_stat;
        end
        sca_pkg::RES_FOUND: begin
          wsec_nxt = 6'(found_r);
        end
        sca_pkg::RES_LOC: begin
          wsec_nxt = 6'(cur_r);
          woff_nxt = rem_r[8:0];
        end
        sca_pkg::RES_SET_FULL: begin
          wres_nxt = sca_pkg::RES_FULL;
        end
        sca_pkg::RES_SET_BAD: begin
          wres_nxt = sca_pkg::RES_BAD;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: loaded from the working result when the slot is free.
  always_comb begin
    ovalid_nxt = ovalid_r && out_stall;
    osec_nxt   = osec_r;
    ooff_nxt   = ooff_r;
    onext_nxt  = onext_r;
    ostat_nxt  = ostat_r;
    ores_nxt   = ores_r;
    if (ctrl.out_load && out_free) begin
      ovalid_nxt = 1'b1;
      osec_nxt   = wsec_r;
      ooff_nxt   = woff_r;
      onext_nxt  = wnext_r;
      ostat_nxt  = wstat_r;
      ores_nxt   = wres_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sec_r    <= sec_nxt;
    s0_r     <= s0_nxt;
    at_end_r <= at_end_nxt;
    lnext_r  <= lnext_nxt;
    lstat_r  <= lstat_nxt;
    cur_r    <= cur_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    ptr_r    <= ptr_nxt;
    pend_r   <= pend_nxt;
    last_r   <= last_nxt;
    hit_r    <= hit_nxt;
    found_r  <= found_nxt;
    keep_r   <= keep_nxt;
    wsec_r   <= wsec_nxt;
    woff_r   <= woff_nxt;
    wnext_r  <= wnext_nxt;
    wstat_r  <= wstat_nxt;
    wres_r   <= wres_nxt;
    osec_r   <= osec_nxt;
    ooff_r   <= ooff_nxt;
    onext_r  <= onext_nxt;
    ostat_r  <= ostat_nxt;
    ores_r   <= ores_nxt;
  end

  assign out_valid         = ovalid_r;
  assign out_result_sector = osec_r;
  assign out_sector_offset = ooff_r;
  assign out_entry_next    = onext_r;
  assign out_entry_status  = ostat_r;
  assign out_status        = ores_r;

endmodule

>>> rtl/sca_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sector chain allocator, attached by the bind at the end.
// Depends on sca_pkg for the status codes and on the top level's port list.
module sca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_result_sector,
  input logic [8:0]  out_sector_offset,
  input logic [5:0]  out_entry_next,
  input logic [1:0]  out_entry_status,
  input logic [1:0]  out_status
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_sector) &&
      $stable(out_sector_offset) && $stable(out_entry_next) &&
      $stable(out_entry_status) && $stable(out_status))
    else $error("stalled result changed");

  // After an input transfer the block is busy with that request.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in progress");

  // A failed request reports no sector, offset or entry.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != sca_pkg::RES_OK) |->
      (out_result_sector == 6'd0) && (out_sector_offset == 9'd0) &&
      (out_entry_next == 6'd0) && (out_entry_status == 2'd0))
    else $error("failed result carries data");

  // An entry read carries no sector or offset, and the status is a defined code.
  a_entry_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_entry_next != 6'd0) || (out_entry_status != 2'd0)) |->
      (out_result_sector == 6'd0) && (out_sector_offset == 9'd0) &&
      (out_entry_status != sca_pkg::ST_INVALID))
    else $error("entry read mixed with locate or allocate result");

endmodule

bind sector_chain_allocator sca_checker u_sca_checker (.*);
